// File: sv/umsp_pkg.sv
// ----------------------------------------------------------------------------
// umsp_pkg: shared types and codes for the umask mode string parser
// Request and status codes, payload types and the reset mask.
// ----------------------------------------------------------------------------
package umsp_pkg;

  typedef logic [1:0]  req_t;
  typedef logic [7:0]  char_t;
  typedef logic [1:0]  status_t;
  typedef logic [11:0] mask_t;

  localparam req_t REQ_CHAR   = 2'd0;
  localparam req_t REQ_END    = 2'd1;
  localparam req_t REQ_REPORT = 2'd2;

  localparam status_t ST_CHANGED = 2'd0;
  localparam status_t ST_INVALID = 2'd1;
  localparam status_t ST_REPORT  = 2'd2;

  localparam mask_t MASK_RESET = 12'o0022;

  typedef struct packed {
    req_t  req_type;
    char_t char_code;
  } item_t;

  typedef struct packed {
    logic    valid;
    status_t status;
    mask_t   mask_value;
  } result_t;

endpackage

// File: sv/umsp_if.sv
// ----------------------------------------------------------------------------
// umsp_in_if / umsp_out_if: valid/ready channels of the mask parser
// Request channel (request type, character) and result channel.
// ----------------------------------------------------------------------------
interface umsp_in_if import umsp_pkg::*; ();
  logic  valid;
  logic  ready;
  req_t  req_type;
  char_t char_code;

  modport source(output valid, req_type, char_code, input ready);
  modport sink(input valid, req_type, char_code, output ready);
endinterface

interface umsp_out_if import umsp_pkg::*; ();
  logic    valid;
  logic    ready;
  status_t status;
  mask_t   mask_value;

  modport source(output valid, status, mask_value, input ready);
  modport sink(input valid, status, mask_value, output ready);
endinterface

// File: sv/umask_mode_string_parser.sv
// ----------------------------------------------------------------------------
// umask_mode_string_parser: file-creation mask with streaming operand parser
// Top level: input register, parser, result register.
// ----------------------------------------------------------------------------
// The block holds a 12-bit file-creation mask (0022 after reset). Feed an
// operand one character per transaction (request type 0), then send an end
// transaction (type 1): the block answers with status 0 and the new mask, or
// status 1 and the unchanged mask if neither the octal reading (up to 07777)
// nor the symbolic reading (who letters ugoa, operators + - =, permissions
// rwxXst or one copy letter ugo, clauses split by commas, at most
// MAX_CLAUSES) is valid. A report transaction (type 2) returns the mask with
// status 2 and leaves a running operand untouched; type 3 is dropped. Only
// end and report produce a result. One transaction is accepted every cycle
// unless the input side stalls; a request waits in the input register and
// the parser writes its result into the result register once the request
// advances. The input side stalls only when a result is waiting in the
// result register and the next request also produces one.
module umask_mode_string_parser import umsp_pkg::*; #(
  parameter int MAX_CLAUSES = 64
) (
  input  logic       clk,
  input  logic       rst_n,
  umsp_in_if.sink    in_ch,
  umsp_out_if.source out_ch
);

  logic    hold_valid;
  item_t   hold_item;
  logic    needs_out;
  logic    out_busy;
  logic    advance;
  result_t res;

  // capture each request transaction
  umsp_in_stage u_in (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_ch      (in_ch),
    .advance    (advance),
    .hold_valid (hold_valid),
    .hold_item  (hold_item)
  );

  // advance the held request unless it needs the result register and that
  // register still holds a result nobody has taken
  assign needs_out = (hold_item.req_type == REQ_END) ||
                     (hold_item.req_type == REQ_REPORT);
  assign advance   = hold_valid && (!needs_out || !out_busy);

  umsp_parser #(
    .MAX_CLAUSES (MAX_CLAUSES)
  ) u_parser (
    .clk   (clk),
    .rst_n (rst_n),
    .fire  (advance),
    .item  (hold_item),
    .res   (res)
  );

  // hold the result until the consumer takes it
  umsp_out_stage u_out (
    .clk    (clk),
    .rst_n  (rst_n),
    .res    (res),
    .out_ch (out_ch),
    .busy   (out_busy)
  );

endmodule

// File: sv/umsp_in_stage.sv
// ----------------------------------------------------------------------------
// umsp_in_stage: request input register
// Holds one request transaction until the parser consumes it.
// ----------------------------------------------------------------------------
module umsp_in_stage import umsp_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  umsp_in_if.sink   in_ch,
  input  logic      advance,
  output logic      hold_valid,
  output item_t     hold_item
);

  logic  valid_r, valid_nxt;
  item_t item_r, item_nxt;
  logic  take;

  assign in_ch.ready = !valid_r || advance;
  assign take        = in_ch.valid && in_ch.ready;

  always_comb begin
    valid_nxt = valid_r;
    item_nxt  = item_r;
    if (take) begin
      valid_nxt          = 1'b1;
      item_nxt.req_type  = in_ch.req_type;
      item_nxt.char_code = in_ch.char_code;
    end else if (advance) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    item_r <= item_nxt;
  end

  assign hold_valid = valid_r;
  assign hold_item  = item_r;

endmodule

// File: sv/umsp_parser.sv
// ----------------------------------------------------------------------------
// umsp_parser: mask register and single-pass operand parser
// Consumes one request per cycle while fire is high, tracks octal and symbolic readings.
// ----------------------------------------------------------------------------
module umsp_parser import umsp_pkg::*; #(
  parameter int MAX_CLAUSES = 64
) (
  input  logic    clk,
  input  logic    rst_n,
  input  logic    fire,
  input  item_t   item,
  output result_t res
);

  typedef enum logic [3:0] {
    PH_WHO      = 4'b0001,
    PH_AFTER_OP = 4'b0010,
    PH_PERM     = 4'b0100,
    PH_COPY     = 4'b1000
  } phase_t;

  typedef enum logic [1:0] {
    OP_NONE = 2'd0,
    OP_ADD  = 2'd1,
    OP_SUB  = 2'd2,
    OP_SET  = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    CP_NONE = 2'd0,
    CP_U    = 2'd1,
    CP_G    = 2'd2,
    CP_O    = 2'd3
  } copy_t;

  localparam char_t CH_U     = 8'h75;
  localparam char_t CH_G     = 8'h67;
  localparam char_t CH_O     = 8'h6F;
  localparam char_t CH_A     = 8'h61;
  localparam char_t CH_R     = 8'h72;
  localparam char_t CH_W     = 8'h77;
  localparam char_t CH_X     = 8'h78;
  localparam char_t CH_XCAP  = 8'h58;
  localparam char_t CH_S     = 8'h73;
  localparam char_t CH_T     = 8'h74;
  localparam char_t CH_PLUS  = 8'h2B;
  localparam char_t CH_MINUS = 8'h2D;
  localparam char_t CH_EQ    = 8'h3D;
  localparam char_t CH_COMMA = 8'h2C;
  localparam char_t CH_ZERO  = 8'h30;
  localparam char_t CH_SEVEN = 8'h37;

  localparam mask_t OCT_SHIFT_MAX = 12'o0777;
  localparam mask_t EXEC_BITS     = 12'o0111;
  localparam logic [6:0] CLAUSE_SAT = 7'd127;
  localparam logic [6:0] CLAUSE_LIM = 7'(MAX_CLAUSES);

  function automatic logic [8:0] class_bits(logic [2:0] who, logic [2:0] perms);
    logic [8:0] b;
    b = '0;
    if (who[0]) b[8:6] = perms;
    if (who[1]) b[5:3] = perms;
    if (who[2]) b[2:0] = perms;
    return b;
  endfunction

  function automatic mask_t apply_op(mask_t w, logic [2:0] who, op_t op,
                                     logic [2:0] perms);
    logic [2:0] wh;
    logic [8:0] bits;
    logic [8:0] allowed;
    mask_t      r;
    wh      = (who != 3'b000) ? who : 3'b111;
    bits    = class_bits(wh, perms);
    allowed = class_bits(wh, 3'b111);
    case (op)
      OP_ADD:  r = w & ~{3'b000, bits};
      OP_SUB:  r = w | {3'b000, bits};
      default: r = (w & ~{3'b000, allowed}) | {3'b000, allowed & ~bits};
    endcase
    return r;
  endfunction

  function automatic logic [2:0] copy_perms(mask_t w, copy_t src);
    logic [2:0] p;
    case (src)
      CP_U:    p = ~w[8:6];
      CP_G:    p = ~w[5:3];
      default: p = ~w[2:0];
    endcase
    return p;
  endfunction

  mask_t      cur_r, cur_nxt;
  mask_t      work_r, work_nxt;
  mask_t      oct_r, oct_nxt;
  logic       oct_ok_r, oct_ok_nxt;
  logic       sym_ok_r, sym_ok_nxt;
  phase_t     phase_r, phase_nxt;
  logic [2:0] who_r, who_nxt;
  op_t        op_r, op_nxt;
  logic [2:0] perm_r, perm_nxt;
  copy_t      src_r, src_nxt;
  logic [6:0] clause_r, clause_nxt;
  logic       char_cnt_r, char_cnt_nxt;

  char_t      c;
  mask_t      work_base;
  mask_t      applied;
  logic [2:0] eff_perms;
  logic       c_is_op, c_is_comma, c_is_oct;
  logic       perm_hit;
  logic [2:0] perm_add;
  op_t        c_op;
  logic [6:0] clause_inc;
  logic       end_ok;
  mask_t      end_val;

  assign c          = item.char_code;
  assign work_base  = char_cnt_r ? work_r : cur_r;
  assign eff_perms  = (phase_r == PH_COPY) ? copy_perms(work_base, src_r) : perm_r;
  assign applied    = apply_op(work_base, who_r, op_r, eff_perms);
  assign c_is_op    = (c == CH_PLUS) || (c == CH_MINUS) || (c == CH_EQ);
  assign c_is_comma = (c == CH_COMMA);
  assign c_is_oct   = (c >= CH_ZERO) && (c <= CH_SEVEN);
  assign c_op       = (c == CH_PLUS) ? OP_ADD : (c == CH_MINUS) ? OP_SUB : OP_SET;
  assign clause_inc = (clause_r < CLAUSE_SAT) ? clause_r + 7'd1 : clause_r;

  // permission letter decode; X only counts when the mask leaves execute open
  always_comb begin
    perm_hit = 1'b1;
    perm_add = 3'b000;
    case (c)
      CH_R:    perm_add = 3'b100;
      CH_W:    perm_add = 3'b010;
      CH_X:    perm_add = 3'b001;
      CH_XCAP: perm_add = ((~cur_r & EXEC_BITS) != '0) ? 3'b001 : 3'b000;
      CH_S:    perm_add = 3'b000;
      CH_T:    perm_add = 3'b000;
      default: perm_hit = 1'b0;
    endcase
  end

  // end-of-operand verdict: octal wins, then a complete symbolic reading
  always_comb begin
    end_ok  = 1'b0;
    end_val = cur_r;
    if (char_cnt_r && oct_ok_r) begin
      end_ok  = 1'b1;
      end_val = oct_r;
    end else if (char_cnt_r && sym_ok_r && phase_r != PH_WHO) begin
      end_ok  = 1'b1;
      end_val = applied;
    end
  end

  always_comb begin
    cur_nxt      = cur_r;
    work_nxt     = work_r;
    oct_nxt      = oct_r;
    oct_ok_nxt   = oct_ok_r;
    sym_ok_nxt   = sym_ok_r;
    phase_nxt    = phase_r;
    who_nxt      = who_r;
    op_nxt       = op_r;
    perm_nxt     = perm_r;
    src_nxt      = src_r;
    clause_nxt   = clause_r;
    char_cnt_nxt = char_cnt_r;
    res.valid      = 1'b0;
    res.status     = ST_REPORT;
    res.mask_value = cur_r;

    if (fire) begin
      case (item.req_type)
        REQ_CHAR: begin
          char_cnt_nxt = 1'b1;
          work_nxt     = work_base;
          if (oct_ok_r) begin
            if (!c_is_oct || oct_r > OCT_SHIFT_MAX) begin
              oct_ok_nxt = 1'b0;
            end else begin
              oct_nxt = {oct_r[8:0], c[2:0]};
            end
          end
          if (sym_ok_r) begin
            // close the pending operator, then follow with op, comma or error
            if ((phase_r == PH_AFTER_OP && !(c == CH_U || c == CH_G || c == CH_O)
                 && !perm_hit) ||
                (phase_r == PH_PERM && !perm_hit) ||
                (phase_r == PH_COPY && (c_is_op || c_is_comma))) begin
              work_nxt = applied;
              if (c_is_op) begin
                op_nxt    = c_op;
                perm_nxt  = 3'b000;
                src_nxt   = CP_NONE;
                phase_nxt = PH_AFTER_OP;
              end else if (c_is_comma) begin
                clause_nxt = clause_inc;
                if (clause_inc >= CLAUSE_LIM) sym_ok_nxt = 1'b0;
                phase_nxt = PH_WHO;
                who_nxt   = 3'b000;
                op_nxt    = OP_NONE;
                perm_nxt  = 3'b000;
                src_nxt   = CP_NONE;
              end else begin
                sym_ok_nxt = 1'b0;
              end
            end else begin
              case (phase_r)
                PH_WHO: begin
                  if (c == CH_U) who_nxt = who_r | 3'b001;
                  else if (c == CH_G) who_nxt = who_r | 3'b010;
                  else if (c == CH_O) who_nxt = who_r | 3'b100;
                  else if (c == CH_A) who_nxt = 3'b111;
                  else if (c_is_op) begin
                    op_nxt    = c_op;
                    perm_nxt  = 3'b000;
                    src_nxt   = CP_NONE;
                    phase_nxt = PH_AFTER_OP;
                  end else sym_ok_nxt = 1'b0;
                end
                PH_AFTER_OP: begin
                  if (c == CH_U) begin
                    src_nxt   = CP_U;
                    phase_nxt = PH_COPY;
                  end else if (c == CH_G) begin
                    src_nxt   = CP_G;
                    phase_nxt = PH_COPY;
                  end else if (c == CH_O) begin
                    src_nxt   = CP_O;
                    phase_nxt = PH_COPY;
                  end else begin
                    perm_nxt  = perm_r | perm_add;
                    phase_nxt = PH_PERM;
                  end
                end
                PH_PERM: begin
                  perm_nxt = perm_r | perm_add;
                end
                default: begin
                  sym_ok_nxt = 1'b0;
                end
              endcase
            end
          end
        end
        REQ_END: begin
          if (end_ok) cur_nxt = end_val;
          work_nxt     = end_ok ? end_val : cur_r;
          oct_nxt      = '0;
          oct_ok_nxt   = 1'b1;
          sym_ok_nxt   = 1'b1;
          phase_nxt    = PH_WHO;
          who_nxt      = 3'b000;
          op_nxt       = OP_NONE;
          perm_nxt     = 3'b000;
          src_nxt      = CP_NONE;
          clause_nxt   = 7'd0;
          char_cnt_nxt = 1'b0;
          res.valid      = 1'b1;
          res.status     = end_ok ? ST_CHANGED : ST_INVALID;
          res.mask_value = end_ok ? end_val : cur_r;
        end
        REQ_REPORT: begin
          res.valid = 1'b1;
        end
        default: begin
          res.valid = 1'b0;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cur_r      <= MASK_RESET;
      work_r     <= '0;
      oct_r      <= '0;
      oct_ok_r   <= 1'b1;
      sym_ok_r   <= 1'b1;
      phase_r    <= PH_WHO;
      who_r      <= 3'b000;
      op_r       <= OP_NONE;
      perm_r     <= 3'b000;
      src_r      <= CP_NONE;
      clause_r   <= 7'd0;
      char_cnt_r <= 1'b0;
    end else begin
      cur_r      <= cur_nxt;
      work_r     <= work_nxt;
      oct_r      <= oct_nxt;
      oct_ok_r   <= oct_ok_nxt;
      sym_ok_r   <= sym_ok_nxt;
      phase_r    <= phase_nxt;
      who_r      <= who_nxt;
      op_r       <= op_nxt;
      perm_r     <= perm_nxt;
      src_r      <= src_nxt;
      clause_r   <= clause_nxt;
      char_cnt_r <= char_cnt_nxt;
    end
  end

  a_end_clears: assert property (@(posedge clk) disable iff (!rst_n)
    (fire && item.req_type == REQ_END) |=> (!char_cnt_r && phase_r == PH_WHO))
    else $error("parse state not cleared after end of operand");

  a_mask_hold: assert property (@(posedge clk) disable iff (!rst_n)
    !(fire && item.req_type == REQ_END) |=> $stable(cur_r))
    else $error("mask changed without an end of operand");

  a_invalid_keeps: assert property (@(posedge clk) disable iff (!rst_n)
    (res.valid && res.status == ST_INVALID) |-> (res.mask_value == cur_r))
    else $error("rejected operand reported a different mask");

  a_empty_fresh: assert property (@(posedge clk) disable iff (!rst_n)
    !char_cnt_r |-> (oct_ok_r && sym_ok_r && oct_r == '0 && clause_r == 7'd0))
    else $error("empty operand carries stale parse state");

endmodule

// File: sv/umsp_out_stage.sv
// ----------------------------------------------------------------------------
// umsp_out_stage: result register
// Holds one result transaction until the consumer takes it.
// ----------------------------------------------------------------------------
module umsp_out_stage import umsp_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  result_t   res,
  umsp_out_if.source out_ch,
  output logic      busy
);

  logic    valid_r, valid_nxt;
  status_t status_r, status_nxt;
  mask_t   mask_r, mask_nxt;

  always_comb begin
    valid_nxt  = valid_r;
    status_nxt = status_r;
    mask_nxt   = mask_r;
    if (res.valid) begin
      valid_nxt  = 1'b1;
      status_nxt = res.status;
      mask_nxt   = res.mask_value;
    end else if (out_ch.ready) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    status_r <= status_nxt;
    mask_r   <= mask_nxt;
  end

  assign out_ch.valid      = valid_r;
  assign out_ch.status     = status_r;
  assign out_ch.mask_value = mask_r;
  assign busy              = valid_r && !out_ch.ready;

endmodule
